// ----- design/scfr_pkg.sv -----
// Package for the serial command frame receiver.
// Holds the phase and event codes, fixed limits and start code decoders.
// Depends on nothing; used by serial_command_frame_receiver.
package scfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned EVENT_W   = 4;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    localparam logic [BYTE_W-1:0] MAX_INDEX = 8'd198;
    localparam logic [BYTE_W-1:0] CR_BYTE   = 8'd13;

    localparam logic REG_RESTRICTED = 1'b0;
    localparam logic REG_DEFER      = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BODY  = 2'd1,
        PH_SUM   = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORED  = 4'd0,
        EV_START    = 4'd1,
        EV_BODY     = 4'd2,
        EV_END      = 4'd3,
        EV_DISPATCH = 4'd4,
        EV_DEFERRED = 4'd5,
        EV_SUMERR   = 4'd6,
        EV_OVERFLOW = 4'd7,
        EV_SKIPARM  = 4'd8,
        EV_SKIPPED  = 4'd9,
        EV_REFUSED  = 4'd10
    } event_t;

    function automatic logic is_free_start(input logic [BYTE_W-1:0] b);
        return b inside {8'd1, 8'd12, 8'd15};
    endfunction

    function automatic logic is_limited_start(input logic [BYTE_W-1:0] b);
        return b inside {8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd11, 8'd16, 8'd17, 8'd20, 8'd22};
    endfunction

endpackage

// ----- design/serial_command_frame_receiver.sv -----
// Serial command frame receiver: frame parser, checksum, defer countdown, counters.
// Each accepted byte's result is registered and presented in the cycle after it is taken.
// Throughput: one byte per cycle; the parser state and the result register
// both update at the accepting edge, and input stalls only while a result waits.
// Reset clears the phase, frame position, checksum, countdown, counters and
// configuration; depends on scfr_pkg.
module serial_command_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scfr_pkg::APB_AW-1:0]   paddr,
    input  logic [scfr_pkg::APB_DW-1:0]   pwdata,
    output logic [scfr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scfr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scfr_pkg::EVENT_W-1:0]  event_res,
    output logic [scfr_pkg::BYTE_W-1:0]   data_byte,
    output logic [scfr_pkg::BYTE_W-1:0]   byte_index,
    output logic [scfr_pkg::BYTE_W-1:0]   frame_length,
    output logic [scfr_pkg::COUNT_W-1:0]  frames_started,
    output logic [scfr_pkg::COUNT_W-1:0]  frames_deferred,
    output logic [scfr_pkg::COUNT_W-1:0]  checksum_errors,
    output logic [scfr_pkg::COUNT_W-1:0]  length_errors
);
    import scfr_pkg::*;

    logic                 restricted_reg;
    logic [COUNT_W-1:0]   defer_init_reg;

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    index_reg, index_next;
    logic [BYTE_W-1:0]    xor_reg, xor_next;
    logic [COUNT_W-1:0]   countdown_reg, countdown_next;
    logic [COUNT_W-1:0]   start_cnt_reg, start_cnt_next;
    logic [COUNT_W-1:0]   defer_cnt_reg, defer_cnt_next;
    logic [COUNT_W-1:0]   sum_cnt_reg, sum_cnt_next;
    logic [COUNT_W-1:0]   ovf_cnt_reg, ovf_cnt_next;

    logic                 out_valid_reg;
    event_t               event_reg, event_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [BYTE_W-1:0]    bidx_reg, bidx_next;
    logic [BYTE_W-1:0]    flen_reg, flen_next;

    logic                 cfg_write;
    logic                 in_take;
    logic [BYTE_W-1:0]    index_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_take   = in_valid & ~in_stall;
    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        if (paddr[2] == REG_DEFER)
        begin
            prdata = {{(APB_DW-COUNT_W){1'b0}}, defer_init_reg};
        end
        else
        begin
            prdata = {{(APB_DW-1){1'b0}}, restricted_reg};
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        index_next     = index_reg;
        xor_next       = xor_reg;
        countdown_next = countdown_reg;
        start_cnt_next = start_cnt_reg;
        defer_cnt_next = defer_cnt_reg;
        sum_cnt_next   = sum_cnt_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        event_next     = EV_IGNORED;
        data_next      = '0;
        bidx_next      = '0;
        flen_next      = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (is_free_start(rx_byte) || (is_limited_start(rx_byte) && !restricted_reg))
                begin
                    data_next      = rx_byte;
                    bidx_next      = index_reg;
                    xor_next       = rx_byte;
                    start_cnt_next = start_cnt_reg + 16'd1;
                    phase_next     = PH_BODY;
                    event_next     = EV_START;
                end
                else if (is_limited_start(rx_byte))
                begin
                    event_next = EV_REFUSED;
                end
                else if (rx_byte == CR_BYTE)
                begin
                    phase_next = PH_SKIP;
                    event_next = EV_SKIPARM;
                end
            end
            PH_BODY:
            begin
                data_next = rx_byte;
                bidx_next = index_inc;
                if (index_inc > MAX_INDEX)
                begin
                    ovf_cnt_next = ovf_cnt_reg + 16'd1;
                    index_next   = '0;
                    xor_next     = '0;
                    phase_next   = PH_IDLE;
                    event_next   = EV_OVERFLOW;
                end
                else
                begin
                    index_next = index_inc;
                    xor_next   = xor_reg ^ rx_byte;
                    if (rx_byte == CR_BYTE)
                    begin
                        phase_next = PH_SUM;
                        event_next = EV_END;
                    end
                    else
                    begin
                        event_next = EV_BODY;
                    end
                end
            end
            PH_SUM:
            begin
                if (rx_byte == xor_reg)
                begin
                    if (!restricted_reg && countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                    if (!restricted_reg && countdown_reg != '0 && countdown_reg != 16'd1)
                    begin
                        defer_cnt_next = defer_cnt_reg + 16'd1;
                        event_next     = EV_DEFERRED;
                    end
                    else
                    begin
                        flen_next  = index_reg;
                        event_next = EV_DISPATCH;
                    end
                end
                else
                begin
                    sum_cnt_next = sum_cnt_reg + 16'd1;
                    event_next   = EV_SUMERR;
                end
                index_next = '0;
                xor_next   = '0;
                phase_next = PH_IDLE;
            end
            PH_SKIP:
            begin
                phase_next = PH_IDLE;
                event_next = EV_SKIPPED;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restricted_reg <= 1'b0;
            defer_init_reg <= '0;
            phase_reg      <= PH_IDLE;
            index_reg      <= '0;
            xor_reg        <= '0;
            countdown_reg  <= '0;
            start_cnt_reg  <= '0;
            defer_cnt_reg  <= '0;
            sum_cnt_reg    <= '0;
            ovf_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_DEFER)
                begin
                    defer_init_reg <= pwdata[COUNT_W-1:0];
                    countdown_reg  <= pwdata[COUNT_W-1:0];
                end
                else
                begin
                    restricted_reg <= pwdata[0];
                end
            end
            if (in_take)
            begin
                phase_reg     <= phase_next;
                index_reg     <= index_next;
                xor_reg       <= xor_next;
                start_cnt_reg <= start_cnt_next;
                defer_cnt_reg <= defer_cnt_next;
                sum_cnt_reg   <= sum_cnt_next;
                ovf_cnt_reg   <= ovf_cnt_next;
                if (!cfg_write || paddr[2] != REG_DEFER)
                begin
                    countdown_reg <= countdown_next;
                end
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            event_reg <= event_next;
            data_reg  <= data_next;
            bidx_reg  <= bidx_next;
            flen_reg  <= flen_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = event_reg;
    assign data_byte       = data_reg;
    assign byte_index      = bidx_reg;
    assign frame_length    = flen_reg;

    // Counters are live registers; they only change on a new transfer, which
    // cannot happen while a result is held.
    assign frames_started  = start_cnt_reg;
    assign frames_deferred = defer_cnt_reg;
    assign checksum_errors = sum_cnt_reg;
    assign length_errors   = ovf_cnt_reg;

endmodule
